// ----- rtl/core/mfrav_pkg.sv -----
// Shared types and codes for the marked frame receiver with address vote.
// Holds item kinds, configuration register indexes, reset values and the control states.
// No dependencies.
package mfrav_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_READ = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_END_MARKER   = 2'd1,
    CFG_ADDRESS_CHAR = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] START_MARKER_RST = 8'd37;
  localparam logic [7:0] END_MARKER_RST   = 8'd94;
  localparam logic [7:0] ADDRESS_CHAR_RST = 8'd70;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY
  } state_t;

endpackage

// ----- rtl/core/mfrav_buf.sv -----
// Byte buffer: synchronous memory with one write and one registered read port.
// Per-entry valid bits make entries never written read as zero after reset.
// No dependencies.
module mfrav_buf #(
  parameter int DEPTH = 160,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       q_r;
  logic             ok_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ok_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      ok_r <= re && vld_r[raddr];
    end
  end

  // unwritten or unread entries give zero
  assign rdata = ok_r ? q_r : 8'd0;

endmodule

// ----- rtl/core/marked_frame_receiver_addr_vote_top.sv -----
// Frame receiver top level: byte handling, address vote, commit copy and read-out.
// Depends on mfrav_pkg and mfrav_buf (receive buffer and frame store).
//
// A received-byte, acknowledge or unused item has its result word registered at the
// accepting edge. For a frame-store read the frame store read port registers the data,
// then the result word is registered in ST_READ, where no item is taken. An end marker
// that wins the address vote returns its result at once, then copies the receive buffer
// into the frame store one slot per cycle through the receive buffer read port: no item
// is taken until the last slot is written. Reset needs no clearing pass: per-slot valid
// bits make both stores read as zero until written. A new item is taken while a result
// word still waits, as long as that word is taken in the same cycle.
module marked_frame_receiver_addr_vote_top #(
  parameter int BUFFER_BYTES = 160
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic       in_parity_error,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_committed,
  output logic       out_frame_ready,
  output logic       out_fault_flag,
  output logic [7:0] out_frame_length,
  output logic [7:0] out_read_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW-1:0] FILL_LIM  = CW'(BUFFER_BYTES);
  localparam logic [8:0]    INDEX_LIM = 9'(BUFFER_BYTES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_BYTES - 1);

  mfrav_pkg::state_t state_r, state_nxt;

  logic [7:0]    start_r, end_r, addr_char_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [7:0]    len_r, len_nxt;
  logic          ready_r, ready_nxt;
  logic          fault_r, fault_nxt;
  logic [7:0]    slot_r [1:3];
  logic [AW-1:0] copy_r;
  logic          cp_wr_en_r;
  logic [AW-1:0] cp_wa_r;

  logic          out_valid_r, out_committed_r, out_ready_flag_r, out_fault_r;
  logic [7:0]    out_len_r, out_rdata_r;

  logic          acc, is_byte, is_read, is_ack;
  logic          is_start, is_end, vote, do_commit, do_append;
  logic          m1, m2, m3;
  logic          rx_we;
  logic [AW-1:0] rx_waddr;
  logic          rx_re, fs_re;
  logic [7:0]    rx_rdata, fs_rdata;
  logic          idx_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= mfrav_pkg::START_MARKER_RST;
      end_r       <= mfrav_pkg::END_MARKER_RST;
      addr_char_r <= mfrav_pkg::ADDRESS_CHAR_RST;
    end else if (cfg_valid) begin
      unique case (mfrav_pkg::cfg_idx_t'(cfg_index))
        mfrav_pkg::CFG_START_MARKER: start_r     <= cfg_data;
        mfrav_pkg::CFG_END_MARKER:   end_r       <= cfg_data;
        mfrav_pkg::CFG_ADDRESS_CHAR: addr_char_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign acc     = in_valid && in_ready;
  assign is_byte = (mfrav_pkg::kind_t'(in_kind) == mfrav_pkg::KIND_BYTE);
  assign is_read = (mfrav_pkg::kind_t'(in_kind) == mfrav_pkg::KIND_READ);
  assign is_ack  = (mfrav_pkg::kind_t'(in_kind) == mfrav_pkg::KIND_ACK);

  // start marker wins when both markers match
  assign is_start = (in_rx_byte == start_r);
  assign is_end   = !is_start && (in_rx_byte == end_r);

  assign m1   = (slot_r[1] == addr_char_r);
  assign m2   = (slot_r[2] == addr_char_r);
  assign m3   = (slot_r[3] == addr_char_r);
  assign vote = (m1 && m2) || (m1 && m3) || (m2 && m3);

  assign do_commit = acc && is_byte && is_end && vote;
  assign do_append = acc && is_byte && !is_start && !is_end && (fill_r < FILL_LIM);
  assign rx_we     = (acc && is_byte && is_start) || do_append;
  assign rx_waddr  = is_start ? '0 : fill_r[AW-1:0];
  assign idx_ok    = ({1'b0, in_read_index} < INDEX_LIM);
  assign fs_re     = acc && is_read && idx_ok;

  always_comb begin
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    ready_nxt = ready_r;
    fault_nxt = fault_r;
    if (acc && is_byte) begin
      if (in_parity_error) begin
        fault_nxt = 1'b1;
      end
      if (is_start) begin
        fill_nxt = CW'(1);
      end else if (do_append) begin
        fill_nxt = fill_r + CW'(1);
      end else if (is_end) begin
        if (vote) begin
          ready_nxt = 1'b1;
          len_nxt   = 8'(fill_r);
        end else begin
          fault_nxt = 1'b0;
        end
      end
    end else if (acc && is_ack) begin
      if (ready_r) begin
        fault_nxt = 1'b0;
      end
      ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      len_r   <= 8'd0;
      ready_r <= 1'b0;
      fault_r <= 1'b0;
      slot_r[1] <= 8'd0;
      slot_r[2] <= 8'd0;
      slot_r[3] <= 8'd0;
    end else begin
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      ready_r <= ready_nxt;
      fault_r <= fault_nxt;
      // mirror the address slots so the vote needs no memory read
      if (rx_we && rx_waddr == AW'(1)) slot_r[1] <= in_rx_byte;
      if (rx_we && rx_waddr == AW'(2)) slot_r[2] <= in_rx_byte;
      if (rx_we && rx_waddr == AW'(3)) slot_r[3] <= in_rx_byte;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfrav_pkg::ST_IDLE: begin
        if (do_commit) begin
          state_nxt = mfrav_pkg::ST_COPY;
        end else if (acc && is_read) begin
          state_nxt = mfrav_pkg::ST_READ;
        end
      end
      mfrav_pkg::ST_READ: state_nxt = mfrav_pkg::ST_IDLE;
      mfrav_pkg::ST_COPY: begin
        if (copy_r == LAST_SLOT) begin
          state_nxt = mfrav_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mfrav_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rx_re    = 1'b0;
    unique case (state_r)
      mfrav_pkg::ST_IDLE: in_ready = !cp_wr_en_r && (!out_valid_r || out_ready);
      mfrav_pkg::ST_READ: ;
      mfrav_pkg::ST_COPY: rx_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mfrav_pkg::ST_IDLE;
      copy_r     <= '0;
      cp_wr_en_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cp_wr_en_r <= rx_re;
      if (do_commit) begin
        copy_r <= '0;
      end else if (rx_re) begin
        copy_r <= copy_r + AW'(1);
      end
    end
  end

  // write address trails the read by the memory latency
  always_ff @(posedge clk) begin
    cp_wa_r <= copy_r;
  end

  mfrav_buf #(.DEPTH(BUFFER_BYTES), .AW(AW)) u_rx_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (in_rx_byte),
    .re    (rx_re),
    .raddr (copy_r),
    .rdata (rx_rdata)
  );

  mfrav_buf #(.DEPTH(BUFFER_BYTES), .AW(AW)) u_frame_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cp_wr_en_r),
    .waddr (cp_wa_r),
    .wdata (rx_rdata),
    .re    (fs_re),
    .raddr (in_read_index[AW-1:0]),
    .rdata (fs_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && !is_read) begin
      out_valid_r <= 1'b1;
    end else if (state_r == mfrav_pkg::ST_READ) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !is_read) begin
      out_committed_r  <= do_commit;
      out_ready_flag_r <= ready_nxt;
      out_fault_r      <= fault_nxt;
      out_len_r        <= len_nxt;
      out_rdata_r      <= 8'd0;
    end else if (state_r == mfrav_pkg::ST_READ) begin
      out_committed_r  <= 1'b0;
      out_ready_flag_r <= ready_r;
      out_fault_r      <= fault_r;
      out_len_r        <= len_r;
      out_rdata_r      <= fs_rdata;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_committed    = out_committed_r;
  assign out_frame_ready  = out_ready_flag_r;
  assign out_fault_flag   = out_fault_r;
  assign out_frame_length = out_len_r;
  assign out_read_data    = out_rdata_r;

endmodule

// ----- test/frame_check_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the marked frame receiver bench: status word type and a class that predicts
// and checks result words. Depends on mfrav_pkg for item kinds, register indexes and reset values.
package frame_check_pkg;
  import mfrav_pkg::*;

  localparam int BUFFER_BYTES = 160;

  typedef struct {
    logic       committed;
    logic       frame_ready;
    logic       fault_flag;
    logic [7:0] frame_length;
    logic [7:0] read_data;
  } status_word_t;

  class frame_status_board;
    logic [7:0]   start_marker;
    logic [7:0]   end_marker;
    logic [7:0]   address_char;
    logic [7:0]   rx_buf [BUFFER_BYTES];
    logic [7:0]   store [BUFFER_BYTES];
    int           fill;
    logic [7:0]   frame_len;
    logic         ready;
    logic         fault;
    status_word_t status_due [$];
    int           mismatches;

    function new();
      start_marker = START_MARKER_RST;
      end_marker   = END_MARKER_RST;
      address_char = ADDRESS_CHAR_RST;
      foreach (rx_buf[i]) begin
        rx_buf[i] = 8'h00;
        store[i]  = 8'h00;
      end
      fill       = 0;
      frame_len  = 8'h00;
      ready      = 1'b0;
      fault      = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [7:0] value);
      case (idx)
        CFG_START_MARKER: start_marker = value;
        CFG_END_MARKER:   end_marker   = value;
        CFG_ADDRESS_CHAR: address_char = value;
        default: ;
      endcase
    endfunction

    // Advance the frame state by one accepted word and queue the status it should produce.
    function void take_word(kind_t kind, logic [7:0] rx_byte, logic parity_error,
                            logic [7:0] read_index);
      status_word_t want;
      int           hits;
      want.committed = 1'b0;
      want.read_data = 8'h00;
      case (kind)
        KIND_BYTE: begin
          if (parity_error)
            fault = 1'b1;
          if (rx_byte == start_marker) begin
            rx_buf[0] = rx_byte;
            fill = 1;
          end else if (rx_byte != end_marker) begin
            if (fill < BUFFER_BYTES) begin
              rx_buf[fill] = rx_byte;
              fill++;
            end
          end else begin
            hits = 0;
            for (int s = 1; s <= 3; s++)
              if (rx_buf[s] == address_char)
                hits++;
            if (hits >= 2) begin
              ready = 1'b1;
              frame_len = 8'(fill);
              store = rx_buf;
              want.committed = 1'b1;
            end else begin
              fault = 1'b0;
            end
          end
        end
        KIND_READ: begin
          if (read_index < BUFFER_BYTES)
            want.read_data = store[read_index];
        end
        KIND_ACK: begin
          if (ready)
            fault = 1'b0;
          ready = 1'b0;
        end
        default: ;
      endcase
      want.frame_ready  = ready;
      want.fault_flag   = fault;
      want.frame_length = frame_len;
      status_due.push_back(want);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_status(status_word_t got);
      status_word_t want;
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual committed %0d ready %0d",
                 $time, got.committed, got.frame_ready);
        mismatches++;
        return;
      end
      want = status_due.pop_front();
      compare_field("committed", want.committed, got.committed);
      compare_field("frame_ready", want.frame_ready, got.frame_ready);
      compare_field("fault_flag", want.fault_flag, got.fault_flag);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("read_data", want.read_data, got.read_data);
    endfunction
  endclass

endpackage

// ----- test/tb_marked_frame_receiver_addr_vote_top.sv -----
`timescale 1ns / 1ps
// Bench top for marked_frame_receiver_addr_vote_top: directed frames, then random frames and
// noise under three stall patterns. Depends on mfrav_pkg, frame_check_pkg and the RTL.
module tb_marked_frame_receiver_addr_vote_top;
  import mfrav_pkg::*;
  import frame_check_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int QUIET_LIMIT   = 2000;

  logic       clk;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_ready;
  logic [1:0] in_kind         = KIND_BYTE;
  logic [7:0] in_rx_byte      = 8'h00;
  logic       in_parity_error = 1'b0;
  logic [7:0] in_read_index   = 8'h00;
  logic       out_valid;
  logic       out_ready       = 1'b0;
  logic       out_committed;
  logic       out_frame_ready;
  logic       out_fault_flag;
  logic [7:0] out_frame_length;
  logic [7:0] out_read_data;
  logic       cfg_valid       = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index       = CFG_START_MARKER;
  logic [7:0] cfg_data        = 8'h00;

  frame_status_board board;
  status_word_t      seen;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                words_sent    = 0;
  int                quiet_cycles  = 0;

  marked_frame_receiver_addr_vote_top #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_rx_byte       (in_rx_byte),
    .in_parity_error  (in_parity_error),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_committed    (out_committed),
    .out_frame_ready  (out_frame_ready),
    .out_fault_flag   (out_fault_flag),
    .out_frame_length (out_frame_length),
    .out_read_data    (out_read_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.committed    = out_committed;
      seen.frame_ready  = out_frame_ready;
      seen.fault_flag   = out_fault_flag;
      seen.frame_length = out_frame_length;
      seen.read_data    = out_read_data;
      board.check_status(seen);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Any handshake counts as progress; the settle wait in drain is the longest quiet stretch.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Returns at the accepting edge with valid still high; the caller drops it when done.
  task automatic send_word(kind_t kind, logic [7:0] rx_byte, logic parity_error,
                           logic [7:0] read_index);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_rx_byte      <= rx_byte;
    in_parity_error <= parity_error;
    in_read_index   <= read_index;
    do @(posedge clk); while (!in_ready);
    board.take_word(kind, rx_byte, parity_error, read_index);
    if (kind != KIND_NONE)
      words_sent++;
  endtask

  task automatic push_byte(logic [7:0] rx_byte, logic parity_error);
    send_word(KIND_BYTE, rx_byte, parity_error, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, value);
  endtask

  task automatic set_markers(logic [7:0] start_byte, logic [7:0] end_byte,
                             logic [7:0] addr_byte);
    write_reg(CFG_START_MARKER, start_byte);
    write_reg(CFG_END_MARKER, end_byte);
    write_reg(CFG_ADDRESS_CHAR, addr_byte);
    write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every outstanding status word, then let any commit copy finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.status_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == board.start_marker || b == board.end_marker);
    return b;
  endfunction

  function automatic logic perr_bit();
    return ($urandom_range(0, 24) == 0);
  endfunction

  task automatic send_frame();
    int body_len;
    int reads;
    push_byte(board.start_marker, perr_bit());
    repeat (3)
      push_byte(($urandom_range(0, 4) != 0) ? board.address_char : body_byte(), perr_bit());
    // now and then overrun the buffer
    body_len = ($urandom_range(0, 11) == 0) ? $urandom_range(150, 170) : $urandom_range(0, 12);
    repeat (body_len)
      push_byte(body_byte(), perr_bit());
    push_byte(board.end_marker, perr_bit());
    reads = $urandom_range(0, 3);
    repeat (reads)
      send_word(KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, body_len + 6)));
    if ($urandom_range(0, 1) != 0)
      send_word(KIND_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise();
    int         pick;
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      pick = $urandom_range(0, 9);
      b = (pick == 0) ? board.start_marker :
          (pick < 3)  ? board.end_marker   : 8'($urandom_range(0, 255));
      send_word(kind_t'($urandom_range(0, 3)), b, ($urandom_range(0, 4) == 0),
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(0, 3) != 0)
        send_frame();
      else
        send_noise();
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 72;

    // reset values: empty store, idle acknowledge, unused kind
    send_word(KIND_READ, 8'h00, 1'b0, 8'd0);
    send_word(KIND_READ, 8'hFF, 1'b1, 8'd255);
    send_word(KIND_ACK, 8'h55, 1'b1, 8'hAA);
    send_word(KIND_NONE, 8'hFF, 1'b1, 8'hFF);
    // end marker with no frame started: vote over cleared slots fails and clears the fault
    push_byte(8'h00, 1'b1);
    push_byte(END_MARKER_RST, 1'b0);
    // accepted frame carrying a parity fault
    push_byte(START_MARKER_RST, 1'b0);
    push_byte(ADDRESS_CHAR_RST, 1'b0);
    push_byte(ADDRESS_CHAR_RST, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(END_MARKER_RST, 1'b0);
    send_word(KIND_READ, 8'h00, 1'b0, 8'd4);
    send_word(KIND_READ, 8'h00, 1'b0, 8'd159);
    send_word(KIND_READ, 8'h00, 1'b0, 8'd160);
    send_word(KIND_ACK, 8'h00, 1'b0, 8'h00);
    send_word(KIND_ACK, 8'h00, 1'b0, 8'h00);
    // rejected vote with a parity error on the end marker itself
    push_byte(START_MARKER_RST, 1'b0);
    push_byte(ADDRESS_CHAR_RST, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(END_MARKER_RST, 1'b1);
    push_byte(END_MARKER_RST, 1'b0);
    drain();

    // start and end marker equal: the byte must restart the frame
    set_markers(START_MARKER_RST, START_MARKER_RST, ADDRESS_CHAR_RST);
    push_byte(START_MARKER_RST, 1'b0);
    push_byte(ADDRESS_CHAR_RST, 1'b0);
    push_byte(ADDRESS_CHAR_RST, 1'b0);
    push_byte(START_MARKER_RST, 1'b0);
    send_word(KIND_READ, 8'h00, 1'b0, 8'd1);
    drain();

    set_markers(START_MARKER_RST, END_MARKER_RST, ADDRESS_CHAR_RST);
    run_random(217);
    drain();

    send_idle_pct = 72;
    recv_idle_pct = 19;
    set_markers(8'hFF, 8'h00, 8'hAA);
    run_random(217);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_markers(8'h01, 8'hFF, 8'h00);
    run_random(217);
    drain();

    if (board.mismatches == 0 && board.status_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mfrav_pkg.sv
rtl/core/mfrav_buf.sv
rtl/core/marked_frame_receiver_addr_vote_top.sv
test/frame_check_pkg.sv
test/tb_marked_frame_receiver_addr_vote_top.sv
